// ===== rtl/core/oba_pkg.sv =====
// Shared types and constants for the one-bit audio output block.
// Used by the front queue, the ring stage, the comparator stage and the top level.
package oba_pkg;

   localparam int RING_DEPTH    = 256;
   localparam int BLOCK_SAMPLES = 32;

   localparam int PTR_W   = $clog2(2 * RING_DEPTH);
   localparam int IDX_W   = $clog2(RING_DEPTH);
   localparam int BLK_W   = $clog2(BLOCK_SAMPLES + 1);
   localparam int FILL_W  = 9;
   localparam int CNT_W   = 32;
   localparam int SMP_W   = 16;
   localparam int THR_W   = 15;
   localparam int LIM_W   = 16;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_W      = 112;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SILENCE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MUTED         = 2'd2;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [THR_W-1:0] THRESHOLD_RST     = 15'd256;
   localparam logic [LIM_W-1:0] SILENCE_LIMIT_RST = 16'd64;

   typedef struct packed {
      logic                    is_tick;
      logic signed [SMP_W-1:0] sample;
   } cmd_type;

   typedef struct packed {
      logic                    is_tick;
      logic                    rejected;
      logic                    underrun;
      logic [FILL_W-1:0]       fill_level;
      logic signed [SMP_W-1:0] sample;
   } ring_item_type;

endpackage

// ===== rtl/core/oba_front.sv =====
// Front part: takes input transfers, decodes them into commands and queues them.
// Depends on oba_pkg.
module oba_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,
   input  logic [15:0]      req_tdata,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output oba_pkg::cmd_type cmd
);

   oba_pkg::cmd_type                 q_ff [oba_pkg::QDEPTH];
   logic [oba_pkg::QPTR_W-1:0]       wr_ff, wr_in;
   logic [oba_pkg::QPTR_W-1:0]       rd_ff, rd_in;
   logic [oba_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                             push;
   logic                             pop;

   assign req_tready = (cnt_ff != oba_pkg::QCNT_W'(oba_pkg::QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign pop        = cmd_valid && cmd_pop;
   assign cmd        = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff].is_tick <= (req_tuser == oba_pkg::ACT_TICK);
         q_ff[wr_ff].sample  <= $signed(req_tdata);
      end
   end

endmodule

// ===== rtl/core/oba_ring.sv =====
// Ring stage: sample ring memory, read and write pointers, fill level and underrun.
// Depends on oba_pkg.
module oba_ring (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  oba_pkg::cmd_type       cmd,
   output logic                   item_valid,
   input  logic                   item_take,
   output oba_pkg::ring_item_type item
);

   logic [oba_pkg::SMP_W-1:0]   ring_mem [oba_pkg::RING_DEPTH];
   logic [oba_pkg::SMP_W-1:0]   rd_data_ff;
   logic [oba_pkg::PTR_W-1:0]   wp_ff, wp_in;
   logic [oba_pkg::PTR_W-1:0]   rp_ff, rp_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_tick_ff, s1_rej_ff, s1_under_ff;
   logic [oba_pkg::FILL_W-1:0]  s1_fill_ff;
   logic [oba_pkg::PTR_W-1:0]   fill_now;
   logic [oba_pkg::PTR_W-1:0]   fill_next;
   logic [oba_pkg::IDX_W-1:0]   wr_idx;
   logic [oba_pkg::IDX_W-1:0]   rd_idx;
   logic                        full;
   logic                        empty;
   logic                        load;
   logic                        do_write;
   logic                        do_read;

   function automatic logic [oba_pkg::PTR_W-1:0] ptr_step(input logic [oba_pkg::PTR_W-1:0] p);
      if (p == oba_pkg::PTR_W'(2 * oba_pkg::RING_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   function automatic logic [oba_pkg::IDX_W-1:0] ptr_idx(input logic [oba_pkg::PTR_W-1:0] p);
      if (p >= oba_pkg::PTR_W'(oba_pkg::RING_DEPTH)) begin
         return oba_pkg::IDX_W'(p - oba_pkg::PTR_W'(oba_pkg::RING_DEPTH));
      end
      return oba_pkg::IDX_W'(p);
   endfunction

   assign load       = cmd_valid && (!s1_valid_ff || item_take);
   assign cmd_pop    = load;
   assign fill_now   = (wp_ff >= rp_ff) ? wp_ff - rp_ff
                                        : wp_ff + oba_pkg::PTR_W'(2 * oba_pkg::RING_DEPTH) - rp_ff;
   assign full       = (fill_now >= oba_pkg::PTR_W'(oba_pkg::RING_DEPTH));
   assign empty      = (wp_ff == rp_ff);
   assign wr_idx     = ptr_idx(wp_ff);
   assign rd_idx     = ptr_idx(rp_ff);
   assign do_write   = load && !cmd.is_tick && !full;
   assign do_read    = load && cmd.is_tick && !empty;

   always_comb begin
      wp_in       = do_write ? ptr_step(wp_ff) : wp_ff;
      rp_in       = do_read ? ptr_step(rp_ff) : rp_ff;
      s1_valid_in = load ? 1'b1 : (item_take ? 1'b0 : s1_valid_ff);
      fill_next   = fill_now;
      if (do_write) begin
         fill_next = fill_now + 1'b1;
      end else if (do_read) begin
         fill_next = fill_now - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         ring_mem[wr_idx] <= cmd.sample;
      end
      if (do_read) begin
         rd_data_ff <= ring_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_tick_ff  <= cmd.is_tick;
         s1_rej_ff   <= !cmd.is_tick && full;
         s1_under_ff <= cmd.is_tick && empty;
         s1_fill_ff  <= oba_pkg::FILL_W'(fill_next);
      end
   end

   assign item_valid      = s1_valid_ff;
   assign item.is_tick    = s1_tick_ff;
   assign item.rejected   = s1_rej_ff;
   assign item.underrun   = s1_under_ff;
   assign item.fill_level = s1_fill_ff;
   assign item.sample     = s1_under_ff ? '0 : $signed(rd_data_ff);

endmodule

// ===== rtl/core/oba_comp.sv =====
// Back end: hysteresis comparator, quiet run, block and statistics counters,
// configuration registers and the result register. Depends on oba_pkg.
module oba_comp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [oba_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [oba_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  item_valid,
   output logic                                  item_take,
   input  oba_pkg::ring_item_type                item,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [oba_pkg::RSP_W-1:0]             rsp_tdata
);

   logic [oba_pkg::THR_W-1:0]  thr_ff;
   logic [oba_pkg::LIM_W-1:0]  lim_ff;
   logic                       muted_ff;
   logic                       level_ff, level_in;
   logic [oba_pkg::LIM_W-1:0]  quiet_ff, quiet_in;
   logic [oba_pkg::BLK_W-1:0]  blk_ff, blk_in;
   logic [oba_pkg::CNT_W-1:0]  ticks_ff, ticks_in;
   logic [oba_pkg::CNT_W-1:0]  edges_ff, edges_in;
   logic [oba_pkg::CNT_W-1:0]  unders_ff, unders_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [oba_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                       changed;
   logic                       refill;
   logic signed [16:0]         s17;
   logic signed [16:0]         t17;
   logic                       above;
   logic                       below;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_tready);
   assign s17       = {item.sample[15], item.sample};
   assign t17       = {2'b00, thr_ff};
   assign above     = (s17 > t17);
   assign below     = (s17 < -t17);

   always_comb begin
      level_in  = level_ff;
      quiet_in  = quiet_ff;
      blk_in    = blk_ff;
      ticks_in  = ticks_ff;
      edges_in  = edges_ff;
      unders_in = unders_ff;
      changed   = 1'b0;
      refill    = 1'b0;
      if (item.is_tick) begin
         ticks_in = ticks_ff + 1'b1;
         if (item.underrun) begin
            unders_in = unders_ff + 1'b1;
         end
         priority if (muted_ff) begin
            level_in = 1'b0;
            quiet_in = lim_ff;
         end else if (above) begin
            level_in = 1'b1;
            quiet_in = '0;
         end else if (below) begin
            level_in = 1'b0;
            quiet_in = '0;
         end else if (quiet_ff < lim_ff) begin
            quiet_in = quiet_ff + 1'b1;
         end else begin
            level_in = 1'b0;
         end
         changed = (level_in != level_ff);
         if (changed) begin
            edges_in = edges_ff + 1'b1;
         end
         if (blk_ff + 1'b1 == oba_pkg::BLK_W'(oba_pkg::BLOCK_SAMPLES)) begin
            blk_in = '0;
            refill = 1'b1;
         end else begin
            blk_in = blk_ff + 1'b1;
         end
      end
      rsp_data_in  = {2'b00, unders_in, edges_in, ticks_in, item.fill_level,
                      item.rejected, refill, item.underrun, changed, level_in};
      rsp_valid_in = item_take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= oba_pkg::THRESHOLD_RST;
         lim_ff       <= oba_pkg::SILENCE_LIMIT_RST;
         muted_ff     <= 1'b1;
         level_ff     <= 1'b0;
         quiet_ff     <= '0;
         blk_ff       <= '0;
         ticks_ff     <= '0;
         edges_ff     <= '0;
         unders_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               oba_pkg::REG_THRESHOLD:     thr_ff   <= csr_wdata[oba_pkg::THR_W-1:0];
               oba_pkg::REG_SILENCE_LIMIT: lim_ff   <= csr_wdata;
               oba_pkg::REG_MUTED:         muted_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (item_take) begin
            level_ff  <= level_in;
            quiet_ff  <= quiet_in;
            blk_ff    <= blk_in;
            ticks_ff  <= ticks_in;
            edges_ff  <= edges_in;
            unders_ff <= unders_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/one_bit_audio_output.sv =====
// Top level of the one-bit audio output: front queue, ring stage and comparator stage.
// Depends on oba_pkg, oba_front, oba_ring and oba_comp.
//
//   channel   direction  payload
//   req_      in         tuser: action; tdata: sample
//   rsp_      out        tdata: result flags, fill level and three counters
//   csr_      in         index 0 threshold, 1 silence limit, 2 muted
//
// One item per cycle sustained while rsp_tready is high; a result passes the queue entry,
// the ring memory read and the result register before it is valid.
// A 4-entry queue parts the front from the back; while a result waits the queue
// takes further transfers until it is full, then req_tready drops. Synchronous reset
// clears pointers and counters and restores the configuration defaults;
// ring contents are left as they are.
module one_bit_audio_output (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,   // [0] action
   input  logic [15:0]   req_tdata,   // [15:0] sample
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [0] pin_high, [1] pin_changed, [2] underrun, [3] refill_request,
   // [4] push_rejected, [13:5] fill_level, [45:14] ticks_total,
   // [77:46] edges_total, [109:78] underruns_total
   output logic [111:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   oba_pkg::cmd_type       cmd;
   oba_pkg::ring_item_type item;
   logic                   cmd_valid;
   logic                   cmd_pop;
   logic                   item_valid;
   logic                   item_take;

   oba_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   oba_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   oba_comp u_comp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== verif/oba_checker.sv =====
`timescale 1ns / 100ps
// Checker for the one-bit audio output: watches the request, result and register ports,
// predicts each result from its own ring, pin and counter state, and compares field by field.
// Depends on oba_pkg for widths, register indexes and action codes.
module oba_checker
   import oba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic              req_tuser,
   input  logic [SMP_W-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned       outstanding,
   output int unsigned       mismatches
);

   // lowest field last, so the packed layout matches rsp_tdata from bit 0 up
   typedef struct packed {
      logic [CNT_W-1:0]  underruns_total;
      logic [CNT_W-1:0]  edges_total;
      logic [CNT_W-1:0]  ticks_total;
      logic [FILL_W-1:0] fill_level;
      logic              push_rejected;
      logic              refill_request;
      logic              underrun;
      logic              pin_changed;
      logic              pin_high;
   } pin_report_type;

   logic [SMP_W-1:0] ring_copy [RING_DEPTH];
   logic [PTR_W-1:0] wr_ptr;
   logic [PTR_W-1:0] rd_ptr;
   logic             pin_level;
   logic [LIM_W-1:0] quiet_run;
   int unsigned      block_ticks;
   logic [CNT_W-1:0] tick_cnt;
   logic [CNT_W-1:0] edge_cnt;
   logic [CNT_W-1:0] under_cnt;
   logic [THR_W-1:0] thr_cfg;
   logic [LIM_W-1:0] limit_cfg;
   logic             mute_cfg;
   pin_report_type   due_reports [$];
   int unsigned      n_results;

   task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                  input logic [CNT_W-1:0] want);
      $display("result %0d: %s is %0h, expected %0h", n_results, what, got, want);
      mismatches++;
   endtask

   task automatic apply_audio_item(input logic action, input logic [SMP_W-1:0] smp,
                                   output pin_report_type rep);
      logic [PTR_W-1:0] fill;
      int               played;
      int               thr;
      logic             prev;
      rep = '0;
      fill = wr_ptr - rd_ptr;
      if (action == ACT_PUSH) begin
         if (fill >= RING_DEPTH) begin
            rep.push_rejected = 1'b1;
         end else begin
            ring_copy[wr_ptr[IDX_W-1:0]] = smp;
            wr_ptr = wr_ptr + 1'b1;
         end
      end else begin
         prev = pin_level;
         played = 0;
         thr = int'(thr_cfg);
         if (rd_ptr != wr_ptr) begin
            played = int'($signed(ring_copy[rd_ptr[IDX_W-1:0]]));
            rd_ptr = rd_ptr + 1'b1;
         end else begin
            rep.underrun = 1'b1;
            under_cnt = under_cnt + 1'b1;
         end
         tick_cnt = tick_cnt + 1'b1;
         if (mute_cfg) begin
            pin_level = 1'b0;
            quiet_run = limit_cfg;
         end else if (played > thr) begin
            pin_level = 1'b1;
            quiet_run = '0;
         end else if (played < -thr) begin
            pin_level = 1'b0;
            quiet_run = '0;
         end else if (quiet_run < limit_cfg) begin
            quiet_run = quiet_run + 1'b1;
         end else begin
            pin_level = 1'b0;
         end
         if (pin_level != prev) begin
            rep.pin_changed = 1'b1;
            edge_cnt = edge_cnt + 1'b1;
         end
         block_ticks++;
         if (block_ticks >= BLOCK_SAMPLES) begin
            block_ticks = 0;
            rep.refill_request = 1'b1;
         end
      end
      rep.pin_high        = pin_level;
      rep.fill_level      = wr_ptr - rd_ptr;
      rep.ticks_total     = tick_cnt;
      rep.edges_total     = edge_cnt;
      rep.underruns_total = under_cnt;
   endtask

   always @(posedge clock) begin
      pin_report_type got;
      pin_report_type want;
      if (reset) begin
         wr_ptr = '0;
         rd_ptr = '0;
         pin_level = 1'b0;
         quiet_run = '0;
         block_ticks = 0;
         tick_cnt = '0;
         edge_cnt = '0;
         under_cnt = '0;
         thr_cfg = THRESHOLD_RST;
         limit_cfg = SILENCE_LIMIT_RST;
         mute_cfg = 1'b1;
         due_reports.delete();
         n_results = 0;
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_THRESHOLD:     thr_cfg = csr_wdata[THR_W-1:0];
               REG_SILENCE_LIMIT: limit_cfg = csr_wdata[LIM_W-1:0];
               REG_MUTED:         mute_cfg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            apply_audio_item(req_tuser, req_tdata, want);
            due_reports.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = pin_report_type'(rsp_tdata[$bits(pin_report_type)-1:0]);
            if (due_reports.size() == 0) begin
               report_mismatch("result with none due, low word", rsp_tdata[CNT_W-1:0], '0);
            end else begin
               want = due_reports.pop_front();
               if (got.pin_high !== want.pin_high)
                  report_mismatch("pin_high", CNT_W'(got.pin_high), CNT_W'(want.pin_high));
               if (got.pin_changed !== want.pin_changed)
                  report_mismatch("pin_changed", CNT_W'(got.pin_changed),
                                  CNT_W'(want.pin_changed));
               if (got.underrun !== want.underrun)
                  report_mismatch("underrun", CNT_W'(got.underrun), CNT_W'(want.underrun));
               if (got.refill_request !== want.refill_request)
                  report_mismatch("refill_request", CNT_W'(got.refill_request),
                                  CNT_W'(want.refill_request));
               if (got.push_rejected !== want.push_rejected)
                  report_mismatch("push_rejected", CNT_W'(got.push_rejected),
                                  CNT_W'(want.push_rejected));
               if (got.fill_level !== want.fill_level)
                  report_mismatch("fill_level", CNT_W'(got.fill_level),
                                  CNT_W'(want.fill_level));
               if (got.ticks_total !== want.ticks_total)
                  report_mismatch("ticks_total", got.ticks_total, want.ticks_total);
               if (got.edges_total !== want.edges_total)
                  report_mismatch("edges_total", got.edges_total, want.edges_total);
               if (got.underruns_total !== want.underruns_total)
                  report_mismatch("underruns_total", got.underruns_total, want.underruns_total);
            end
            n_results++;
         end
      end
      outstanding <= due_reports.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the one-bit audio output testbench: clock, reset, register phases, request
// stimulus, result back-pressure and the verdict. Depends on oba_pkg, oba_checker
// and the one_bit_audio_output block.
module testbench;
   import oba_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;
   logic [SMP_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned      outstanding;
   int unsigned      mismatches;
   int unsigned      idle_cycles = 0;
   int unsigned      stall_left = 0;
   bit               gaps_on = 1'b0;
   bit               stalls_on = 1'b0;
   logic [THR_W-1:0] cur_thr = THRESHOLD_RST;

   one_bit_audio_output u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   oba_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      forever begin
         @(negedge clock);
         if (stall_left == 0 && stalls_on)
            stall_left = idle_span();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [SMP_W-1:0] pick_sample();
      int t;
      int v;
      t = int'(cur_thr);
      case ($urandom_range(0, 7))
         2:       v = t + 1;
         3:       v = -t - 1;
         4:       v = t;
         5:       v = -t;
         6, 7:    v = int'($urandom_range(0, 2 * t)) - t;
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      if (v > 32767)
         v = 32767;
      return v[SMP_W-1:0];
   endfunction

   task automatic send_item(input logic action, input logic [SMP_W-1:0] smp);
      int unsigned gap;
      gap = gaps_on ? idle_span() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every due result has arrived
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [THR_W-1:0] thr, input logic [LIM_W-1:0] lim,
                             input logic mute);
      drain_results();
      csr_write(REG_THRESHOLD, CSR_DATA_W'(thr));
      csr_write(REG_SILENCE_LIMIT, lim);
      csr_write(REG_MUTED, CSR_DATA_W'(mute));
      @(negedge clock);
      csr_we <= 1'b0;
      cur_thr = thr;
   endtask

   task automatic random_traffic(input int unsigned n_items);
      int unsigned sent;
      int unsigned run;
      logic        action;
      sent = 0;
      while (sent < n_items) begin
         action = $urandom_range(0, 1) ? ACT_TICK : ACT_PUSH;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
         repeat (run) begin
            send_item(action, pick_sample());
            sent++;
         end
         if ($urandom_range(0, 29) == 0)
            drain_results();
      end
   endtask

   initial begin
      logic [THR_W-1:0] thr;
      logic [LIM_W-1:0] lim;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // muted after reset: ticks hold the pin low whatever is played
      send_item(ACT_TICK, 16'h7FFF);
      send_item(ACT_PUSH, 16'h7FFF);
      send_item(ACT_TICK, 16'h0000);

      // crossings either way, quiet run up to its limit, forced low from high
      set_config(15'd256, 16'd2, 1'b0);
      send_item(ACT_PUSH, 16'h7FFF);
      send_item(ACT_PUSH, 16'h8000);
      send_item(ACT_PUSH, 16'd257);
      send_item(ACT_PUSH, 16'd256);
      send_item(ACT_PUSH, -16'sd256);
      send_item(ACT_PUSH, 16'd0);
      send_item(ACT_PUSH, -16'sd257);
      repeat (8) send_item(ACT_TICK, 16'hFFFF);

      // widest threshold and limit
      set_config(15'd32767, 16'd65535, 1'b0);
      send_item(ACT_PUSH, 16'h8000);
      send_item(ACT_PUSH, 16'h7FFF);
      send_item(ACT_TICK, 16'h0000);
      send_item(ACT_TICK, 16'h0000);

      // zero threshold and limit, quiet run left above the new limit
      set_config(15'd0, 16'd0, 1'b0);
      send_item(ACT_PUSH, 16'd0);
      send_item(ACT_PUSH, 16'd1);
      send_item(ACT_PUSH, 16'hFFFF);
      repeat (3) send_item(ACT_TICK, 16'h5555);

      // fill the ring past full back to back, then play part of it out
      set_config(15'd100, 16'd5, 1'b0);
      stalls_on = 1'b1;
      repeat (262) send_item(ACT_PUSH, pick_sample());
      repeat (40) send_item(ACT_TICK, pick_sample());

      repeat (8) begin
         case ($urandom_range(0, 3))
            0:       thr = 15'd0;
            1:       thr = 15'd32767;
            2:       thr = THR_W'($urandom_range(1, 64));
            default: thr = THR_W'($urandom_range(0, 32767));
         endcase
         case ($urandom_range(0, 3))
            0:       lim = 16'd0;
            1:       lim = 16'd65535;
            default: lim = LIM_W'($urandom_range(1, 12));
         endcase
         set_config(thr, lim, $urandom_range(0, 5) == 0);
         gaps_on = ($urandom_range(0, 1) == 1);
         stalls_on = ($urandom_range(0, 1) == 1);
         random_traffic(40);
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/oba_pkg.sv
rtl/core/oba_front.sv
rtl/core/oba_ring.sv
rtl/core/oba_comp.sv
rtl/core/one_bit_audio_output.sv
verif/oba_checker.sv
verif/testbench.sv
